FILE: rtl/eci_pkg.sv
// Package for the easing curve interpolator: fixed-point widths, curve codes,
// back-out constants and the pipeline stage vector type. No dependencies.
`default_nettype none
package eci_pkg;

	localparam int FRAC_BITS = 16;
	localparam int T_W       = FRAC_BITS + 1;      // progress, clamped to ONE
	localparam int Q_W       = T_W + 1;            // signed curve operand
	localparam int SQ_W      = 2 * Q_W;            // operand products
	localparam int C_W       = FRAC_BITS + 3;      // back-out constants, signed
	localparam int M_W       = C_W + Q_W;          // constant products
	localparam int W_W       = FRAC_BITS + 4;      // weight, signed
	localparam int VAL_W     = 32;
	localparam int DIFF_W    = VAL_W + 1;
	localparam int PROD_W    = DIFF_W + W_W;
	localparam int SUM_W     = PROD_W - FRAC_BITS + 1;
	localparam int NSTG      = 7;

	localparam longint ONE_L  = longint'(1) << FRAC_BITS;
	localparam longint HALF_L = longint'(1) << (FRAC_BITS - 1);
	localparam longint C1_L   = (longint'(170158) * ONE_L + 50000) / 100000;
	localparam longint C3_L   = C1_L + ONE_L;

	localparam logic [T_W-1:0]           ONE_T  = T_W'(ONE_L);
	localparam logic [T_W-1:0]           HALF_T = T_W'(HALF_L);
	localparam logic signed [C_W-1:0]    C1_Q   = C_W'(C1_L);
	localparam logic signed [C_W-1:0]    C3_Q   = C_W'(C3_L);
	localparam logic signed [W_W-1:0]    ONE_W  = W_W'(ONE_L);
	localparam logic signed [SQ_W-1:0]   HALF_SQ = SQ_W'(HALF_L);
	localparam logic signed [M_W-1:0]    HALF_M  = M_W'(HALF_L);
	localparam logic signed [PROD_W-1:0] HALF_P  = PROD_W'(HALF_L);

	localparam int IN_DATA_W  = ((2 * VAL_W + T_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = VAL_W;

	typedef enum logic [2:0] {
		CURVE_LINEAR   = 3'd0,
		CURVE_EASE_IN  = 3'd1,
		CURVE_EASE_OUT = 3'd2,
		CURVE_IN_OUT   = 3'd3,
		CURVE_BACK_OUT = 3'd4
	} curve_t;

	typedef logic [NSTG-1:0] stage_en_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  start;
		logic signed [DIFF_W-1:0] diff;
	} side_t;

endpackage
`default_nettype wire

FILE: rtl/easing_curve_interpolator.sv
// Easing curve interpolator top level: stream ports, stage valid bits and
// stall chain. Instantiates eci_weight and eci_blend; uses eci_pkg.
//
// channel  dir  tdata                         tuser
// s_axis   in   start, end, progress, pad     curve
// m_axis   out  value                         saturated
//
// Seven stages; one request per cycle is accepted unless the pipeline is full and the output stalled.
// The square, cube, constant-product and blend multipliers each sit in a stage of their own.
// Each stage holds while the one after it is full and stalled; empty stages fill.
// Reset clears the stage valid bits only.
`default_nettype none
module easing_curve_interpolator (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire  [eci_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // start[31:0], end[63:32], progress[80:64]
	input  wire  [2:0]                        s_axis_tuser,  // curve
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	output logic [eci_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // value
	output logic                              m_axis_tuser   // saturated
);

	localparam int END_LO  = eci_pkg::VAL_W;
	localparam int PROG_LO = 2 * eci_pkg::VAL_W;

	eci_pkg::stage_en_t               en;
	logic [eci_pkg::NSTG-1:0]         v_q;
	eci_pkg::side_t                   side_s5;
	logic signed [eci_pkg::W_W-1:0]   weight_s5;
	logic signed [eci_pkg::VAL_W-1:0] value_s7;
	logic                             sat_s7;

	always_comb begin
		en[eci_pkg::NSTG-1] = !v_q[eci_pkg::NSTG-1] || m_axis_tready;
		for (int k = eci_pkg::NSTG - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < eci_pkg::NSTG; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	eci_weight u_weight (
		.clk         (clk),
		.en          (en),
		.curve       (s_axis_tuser),
		.start_value (s_axis_tdata[END_LO-1:0]),
		.end_value   (s_axis_tdata[PROG_LO-1:END_LO]),
		.progress    (s_axis_tdata[PROG_LO+eci_pkg::T_W-1:PROG_LO]),
		.weight_s5   (weight_s5),
		.side_s5     (side_s5)
	);

	eci_blend u_blend (
		.clk       (clk),
		.en        (en),
		.weight_s5 (weight_s5),
		.side_s5   (side_s5),
		.value_s7  (value_s7),
		.sat_s7    (sat_s7)
	);

	assign s_axis_tready = en[0];
	assign m_axis_tvalid = v_q[eci_pkg::NSTG-1];
	assign m_axis_tdata  = value_s7;
	assign m_axis_tuser  = sat_s7;

endmodule
`default_nettype wire

FILE: rtl/eci_weight.sv
// Weight pipeline, stages 1 to 5: clamps t, forms the curve operand, square,
// cube, back-out constant products and the final weight. Uses eci_pkg.
`default_nettype none
module eci_weight (
	input  wire                                  clk,
	input  wire  eci_pkg::stage_en_t             en,
	input  wire  [2:0]                           curve,
	input  wire  signed [eci_pkg::VAL_W-1:0]     start_value,
	input  wire  signed [eci_pkg::VAL_W-1:0]     end_value,
	input  wire  [eci_pkg::T_W-1:0]              progress,
	output logic signed [eci_pkg::W_W-1:0]       weight_s5,
	output eci_pkg::side_t                       side_s5
);

	logic [eci_pkg::T_W-1:0]          t_cl;
	logic signed [eci_pkg::Q_W-1:0]   op_c;

	logic [2:0]                       curve_s1, curve_s2, curve_s3, curve_s4;
	logic                             low_s1, low_s2, low_s3, low_s4;
	logic signed [eci_pkg::Q_W-1:0]   op_s1, op_s2, op_s3, op_s4;
	eci_pkg::side_t                   side_s1, side_s2, side_s3, side_s4;

	logic signed [eci_pkg::SQ_W-1:0]  sq_full, sq_rnd, sq_sh;
	logic signed [eci_pkg::Q_W-1:0]   sq_s2, sq_s3, sq_s4;
	logic signed [eci_pkg::SQ_W-1:0]  cu_full, cu_rnd, cu_sh;
	logic signed [eci_pkg::Q_W-1:0]   cu_s3, cu_s4;
	logic signed [eci_pkg::M_W-1:0]   m3_c, m1_c, m3_s4, m1_s4;
	logic signed [eci_pkg::M_W-1:0]   m3_rnd, m1_rnd, m3_sh, m1_sh;
	logic signed [eci_pkg::W_W-1:0]   cu_w, sq_w, op_w, w_c;

	// stage 1: clamp and operand select
	always_comb begin
		t_cl = (progress > eci_pkg::ONE_T) ? eci_pkg::ONE_T : progress;
		case (curve)
			eci_pkg::CURVE_EASE_OUT: op_c = eci_pkg::Q_W'(eci_pkg::ONE_T) - eci_pkg::Q_W'(t_cl);
			eci_pkg::CURVE_BACK_OUT: op_c = eci_pkg::Q_W'(t_cl) - eci_pkg::Q_W'(eci_pkg::ONE_T);
			default:                 op_c = eci_pkg::Q_W'(t_cl);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			curve_s1      <= curve;
			low_s1        <= t_cl < eci_pkg::HALF_T;
			op_s1         <= op_c;
			side_s1.start <= start_value;
			side_s1.diff  <= eci_pkg::DIFF_W'(end_value) - eci_pkg::DIFF_W'(start_value);
		end
	end

	// stage 2: square
	always_comb begin
		sq_full = op_s1 * op_s1;
		sq_rnd  = sq_full + eci_pkg::HALF_SQ;
		sq_sh   = sq_rnd >>> eci_pkg::FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			curve_s2 <= curve_s1;
			low_s2   <= low_s1;
			op_s2    <= op_s1;
			side_s2  <= side_s1;
			sq_s2    <= sq_sh[eci_pkg::Q_W-1:0];
		end
	end

	// stage 3: cube
	always_comb begin
		cu_full = sq_s2 * op_s2;
		cu_rnd  = cu_full + eci_pkg::HALF_SQ;
		cu_sh   = cu_rnd >>> eci_pkg::FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			curve_s3 <= curve_s2;
			low_s3   <= low_s2;
			op_s3    <= op_s2;
			side_s3  <= side_s2;
			sq_s3    <= sq_s2;
			cu_s3    <= cu_sh[eci_pkg::Q_W-1:0];
		end
	end

	// stage 4: back-out constant products
	always_comb begin
		m3_c = eci_pkg::C3_Q * cu_s3;
		m1_c = eci_pkg::C1_Q * sq_s3;
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			curve_s4 <= curve_s3;
			low_s4   <= low_s3;
			op_s4    <= op_s3;
			side_s4  <= side_s3;
			sq_s4    <= sq_s3;
			cu_s4    <= cu_s3;
			m3_s4    <= m3_c;
			m1_s4    <= m1_c;
		end
	end

	// stage 5: weight select
	always_comb begin
		m3_rnd = m3_s4 + eci_pkg::HALF_M;
		m1_rnd = m1_s4 + eci_pkg::HALF_M;
		m3_sh  = m3_rnd >>> eci_pkg::FRAC_BITS;
		m1_sh  = m1_rnd >>> eci_pkg::FRAC_BITS;
		cu_w   = eci_pkg::W_W'(cu_s4);
		sq_w   = eci_pkg::W_W'(sq_s4);
		op_w   = eci_pkg::W_W'(op_s4);
		case (curve_s4)
			eci_pkg::CURVE_EASE_IN:  w_c = cu_w;
			eci_pkg::CURVE_EASE_OUT: w_c = eci_pkg::ONE_W - cu_w;
			eci_pkg::CURVE_IN_OUT:   w_c = low_s4 ? (sq_w <<< 1)
				: (cu_w <<< 2) - (sq_w <<< 2) + eci_pkg::ONE_W;
			eci_pkg::CURVE_BACK_OUT: w_c = eci_pkg::ONE_W + m3_sh[eci_pkg::W_W-1:0]
				+ m1_sh[eci_pkg::W_W-1:0];
			default:                 w_c = op_w;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			weight_s5 <= w_c;
			side_s5   <= side_s4;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/eci_blend.sv
// Blend pipeline, stages 6 and 7: (end - start) * weight, rounding, the add of
// start and 32-bit saturation. Uses eci_pkg.
`default_nettype none
module eci_blend (
	input  wire                                  clk,
	input  wire  eci_pkg::stage_en_t             en,
	input  wire  signed [eci_pkg::W_W-1:0]       weight_s5,
	input  wire  eci_pkg::side_t                 side_s5,
	output logic signed [eci_pkg::VAL_W-1:0]     value_s7,
	output logic                                 sat_s7
);

	logic signed [eci_pkg::PROD_W-1:0] prod_c, prod_s6, prod_rnd, prod_sh;
	logic signed [eci_pkg::VAL_W-1:0]  start_s6;
	logic signed [eci_pkg::SUM_W-1:0]  sum_c;
	logic [eci_pkg::SUM_W-eci_pkg::VAL_W:0] hi;
	logic                              fits;

	assign prod_c = side_s5.diff * weight_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			prod_s6  <= prod_c;
			start_s6 <= side_s5.start;
		end
	end

	always_comb begin
		prod_rnd = prod_s6 + eci_pkg::HALF_P;
		prod_sh  = prod_rnd >>> eci_pkg::FRAC_BITS;
		sum_c    = eci_pkg::SUM_W'(start_s6) + prod_sh[eci_pkg::SUM_W-1:0];
		hi       = sum_c[eci_pkg::SUM_W-1:eci_pkg::VAL_W-1];
		fits     = (&hi) || !(|hi);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			sat_s7 <= !fits;
			if (fits) begin
				value_s7 <= sum_c[eci_pkg::VAL_W-1:0];
			end else if (sum_c[eci_pkg::SUM_W-1]) begin
				value_s7 <= {1'b1, {(eci_pkg::VAL_W-1){1'b0}}};
			end else begin
				value_s7 <= {1'b0, {(eci_pkg::VAL_W-1){1'b1}}};
			end
		end
	end

endmodule
`default_nettype wire

FILE: bench/easing_curve_interpolator_tb.sv
// Self-checking bench for easing_curve_interpolator: directed corner requests, then
// random ones with idle gaps on both sides and long output holds. Depends on eci_pkg.
`timescale 1ns / 100ps

module easing_curve_interpolator_tb;

	import eci_pkg::*;

	localparam int IN_W        = eci_pkg::IN_DATA_W;
	localparam int RANDOM_REQS = 850;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_WAIT  = 2 * NSTG + 4;

	localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
	localparam logic [31:0] VAL_MAX  = 32'h7FFF_FFFF;
	localparam logic [16:0] T_ONE    = 17'd65536;
	localparam logic [16:0] T_HALF   = 17'd32768;
	localparam logic [16:0] T_TOP    = 17'h1FFFF;

	typedef struct packed {
		logic [31:0] value;
		logic        saturated;
	} eased_result_t;

	class eased_value_board;
		eased_result_t expected_values[$];
		int unsigned   mismatches;

		function longint round_q(longint x);
			return (x + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		endfunction

		function longint curve_weight(logic [2:0] curve, longint t);
			longint unit_q;
			longint c1;
			longint c3;
			longint p;
			longint p2;
			longint t2;
			unit_q = longint'(1) <<< FRAC_BITS;
			case (curve)
				CURVE_EASE_IN: begin
					t2 = round_q(t * t);
					return round_q(t2 * t);
				end
				CURVE_EASE_OUT: begin
					p  = unit_q - t;
					p2 = round_q(p * p);
					return unit_q - round_q(p2 * p);
				end
				CURVE_IN_OUT: begin
					t2 = round_q(t * t);
					if (t < (unit_q >>> 1))
						return 2 * t2;
					return 4 * round_q(t2 * t) - 4 * t2 + unit_q;
				end
				CURVE_BACK_OUT: begin
					c1 = (longint'(170158) * unit_q + 50000) / 100000;
					c3 = c1 + unit_q;
					p  = t - unit_q;
					p2 = round_q(p * p);
					return unit_q + round_q(c3 * round_q(p2 * p)) + round_q(c1 * p2);
				end
				default: return t;
			endcase
		endfunction

		function void note_request(logic [2:0] curve, logic signed [31:0] start_value,
				logic signed [31:0] end_value, logic [16:0] progress);
			longint t;
			longint w;
			longint r;
			eased_result_t res;
			t = longint'(progress);
			if (t > (longint'(1) <<< FRAC_BITS))
				t = longint'(1) <<< FRAC_BITS;
			w = curve_weight(curve, t);
			r = longint'(start_value)
				+ round_q((longint'(end_value) - longint'(start_value)) * w);
			res.saturated = 1'b0;
			if (r > 64'sh7FFF_FFFF) begin
				r = 64'sh7FFF_FFFF;
				res.saturated = 1'b1;
			end else if (r < -64'sh8000_0000) begin
				r = -64'sh8000_0000;
				res.saturated = 1'b1;
			end
			res.value = r[31:0];
			expected_values.push_back(res);
		endfunction

		task report(string msg);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_result(logic [31:0] value, logic saturated);
			eased_result_t exp_res;
			if (expected_values.size() == 0) begin
				report($sformatf("unexpected result value=%h saturated=%b", value, saturated));
			end else begin
				exp_res = expected_values.pop_front();
				if (value !== exp_res.value)
					report($sformatf("value %h, expected %h", value, exp_res.value));
				if (saturated !== exp_res.saturated)
					report($sformatf("saturated %b, expected %b", saturated,
						exp_res.saturated));
			end
		endtask
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_axis_tvalid = 1'b0;
	logic            s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic [2:0]      s_axis_tuser = '0;
	logic            m_axis_tvalid;
	logic            m_axis_tready = 1'b0;
	logic [31:0]     m_axis_tdata;
	logic            m_axis_tuser;

	eased_value_board board = new();
	bit               idle_on = 1'b1;
	bit               hold_request = 1'b0;
	int               hold_left = 0;
	int               quiet_cycles = 0;

	easing_curve_interpolator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.note_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
					s_axis_tdata[80:64]);
			if (m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tdata, m_axis_tuser);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// output side: random stalls, plus long holds to back up the pipeline
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (!arst_n)
				m_axis_tready <= 1'b0;
			else if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(99) < 21)
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= 1'b1;
		end
	end

	task send_request(logic [2:0] curve, logic [31:0] start_value, logic [31:0] end_value,
			logic [16:0] progress);
		while (idle_on && $urandom_range(99) < 21) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= curve;
		s_axis_tdata  <= {progress, end_value, start_value};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2, 3: return {{12{r[19]}}, r[19:0]};
			4: return {{4{r[27]}}, r[27:0]};
			default: return r;
		endcase
	endfunction

	function automatic logic [16:0] pick_progress();
		case ($urandom_range(9))
			0: return T_ONE;
			1: return 17'd0;
			2: return 17'($urandom_range(131071));
			3: return 17'($urandom_range(32760, 32776));
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every curve code at both ends of progress, full-range endpoints
		for (int c = 0; c < 8; c++) begin
			send_request(3'(c), VAL_MIN, VAL_MAX, 17'd0);
			send_request(3'(c), VAL_MAX, VAL_MIN, T_ONE);
		end
		// progress above one is clamped
		send_request(CURVE_LINEAR, 32'h0001_0000, 32'hFFFF_0000, T_TOP);
		send_request(CURVE_BACK_OUT, 32'h0000_0000, 32'h1234_5678, 17'h10001);
		// in-out around the midpoint
		send_request(CURVE_IN_OUT, 32'hFFF0_0000, 32'h0010_0000, T_HALF - 1);
		send_request(CURVE_IN_OUT, 32'hFFF0_0000, 32'h0010_0000, T_HALF);
		// back-out overshoot clips at both rails
		send_request(CURVE_BACK_OUT, 32'h0000_0000, VAL_MAX, 17'd45000);
		send_request(CURVE_BACK_OUT, 32'h0000_0000, VAL_MIN, 17'd45000);
		send_request(CURVE_BACK_OUT, VAL_MAX, VAL_MIN, 17'd50000);
		// rounding with a tiny span
		send_request(CURVE_EASE_OUT, 32'hFFFF_FFFF, 32'h0000_0000, 17'd32768);
		send_request(3'd7, 32'h0000_0001, 32'hFFFF_FFFF, 17'd1);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i == 250)
				idle_on = 1'b0;
			if (i == 400)
				idle_on = 1'b1;
			if (i == 100 || i == 320 || i == 600)
				hold_request = 1'b1;
			send_request(3'($urandom_range(7)), pick_value(), pick_value(), pick_progress());
		end
		s_axis_tvalid <= 1'b0;

		while (board.expected_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (board.mismatches == 0 && board.expected_values.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
